### hw/rtl/signed_varint_codec_assert.svh
// Assertion macros shared by the signed varint codec RTL.
// Expects clk and rst_n in the scope of every use.
`ifndef SIGNED_VARINT_CODEC_ASSERT_SVH
`define SIGNED_VARINT_CODEC_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SVC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SVC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/svc_pkg.sv
// Shared types and constants for the signed varint codec.
// No dependencies.
`timescale 1ns / 1ps

package svc_pkg;

    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    localparam int VAL_W   = 32;
    localparam int BYTE_W  = 8;
    localparam int CNT_W   = 3;
    localparam int TAIL_W  = 25;   // folded value bits above the first six

    localparam logic [CNT_W-1:0] MAX_DEC_CNT = 3'd4;

    // One request classified by the front end.
    typedef struct packed {
        logic              dec;     // decode request
        logic              sign;    // encode: original sign
        logic [CNT_W-1:0]  nbytes;  // encode: bytes to emit, 1..5
        logic [VAL_W-1:0]  data;    // encode: folded value; decode: byte in [7:0]
    } cmd_t;

    // One result item.
    typedef struct packed {
        logic [BYTE_W-1:0] byte_out;
        logic [VAL_W-1:0]  value_out;
        logic              value_valid;
        logic              last;
    } res_t;

endpackage

### hw/rtl/svc_front.sv
// Front end: holds the mode register, accepts requests and classifies them.
// Depends on svc_pkg.
`timescale 1ns / 1ps

module svc_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  logic signed [31:0]  value,
    input  logic [7:0]          byte_in,
    input  logic                cfg_valid,
    input  logic                cfg_data,
    input  logic                q_full,
    output logic                cmd_push,
    output svc_pkg::cmd_t       cmd
);

    logic        mode_reg;
    logic [31:0] folded;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= svc_pkg::MODE_ENCODE;
        end
        else if (cfg_valid)
        begin
            mode_reg <= cfg_data;
        end
    end

    assign folded   = value[31] ? ~value : value;
    assign cmd_push = push && !q_full;

    always_comb
    begin
        cmd      = '0;
        cmd.dec  = (mode_reg == svc_pkg::MODE_DECODE);
        cmd.sign = value[31];
        if (cmd.dec)
        begin
            cmd.data = {24'd0, byte_in};
        end
        else
        begin
            cmd.data = folded;
        end
        if (folded[30:6] == '0)
        begin
            cmd.nbytes = 3'd1;
        end
        else if (folded[30:13] == '0)
        begin
            cmd.nbytes = 3'd2;
        end
        else if (folded[30:20] == '0)
        begin
            cmd.nbytes = 3'd3;
        end
        else if (folded[30:27] == '0)
        begin
            cmd.nbytes = 3'd4;
        end
        else
        begin
            cmd.nbytes = 3'd5;
        end
    end

endmodule

### hw/rtl/svc_cmd_q.sv
// Two-entry request queue between front end and back end.
// Depends on svc_pkg.
`timescale 1ns / 1ps

module svc_cmd_q (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  svc_pkg::cmd_t  wr_data,
    input  logic           rd_en,
    output svc_pkg::cmd_t  head,
    output logic           head_valid,
    output logic           full
);

    svc_pkg::cmd_t mem_reg [2];
    logic          wr_ptr_reg;
    logic          wr_ptr_next;
    logic          rd_ptr_reg;
    logic          rd_ptr_next;
    logic [1:0]    cnt_reg;
    logic [1:0]    cnt_next;

    assign head       = mem_reg[rd_ptr_reg];
    assign head_valid = (cnt_reg != 2'd0);
    assign full       = (cnt_reg == 2'd2);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ wr_en;
        rd_ptr_next = rd_ptr_reg ^ rd_en;
        cnt_next    = cnt_reg + {1'b0, wr_en} - {1'b0, rd_en};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

### hw/rtl/svc_back.sv
// Back end: byte sequencer for encode, accumulator for decode, output buffer.
// Depends on svc_pkg and signed_varint_codec_assert.svh.
`timescale 1ns / 1ps
`include "signed_varint_codec_assert.svh"

module svc_back (
    input  logic           clk,
    input  logic           rst_n,
    input  svc_pkg::cmd_t  head,
    input  logic           head_valid,
    output logic           cmd_pop,
    input  logic           pop,
    output logic           empty,
    output svc_pkg::res_t  res_head
);

    logic [svc_pkg::CNT_W-1:0]  rem_reg;
    logic [svc_pkg::CNT_W-1:0]  rem_next;
    logic [svc_pkg::TAIL_W-1:0] cur_reg;
    logic [svc_pkg::TAIL_W-1:0] cur_next;
    logic [31:0]                acc_reg;
    logic [31:0]                acc_next;
    logic [svc_pkg::CNT_W-1:0]  dcnt_reg;
    logic [svc_pkg::CNT_W-1:0]  dcnt_next;
    logic                       sign_reg;
    logic                       sign_next;

    svc_pkg::res_t              ob_mem_reg [2];
    logic                       ob_wr_reg;
    logic                       ob_rd_reg;
    logic [1:0]                 ob_cnt_reg;

    svc_pkg::res_t              res;
    logic                       emit;
    logic                       ob_pop;
    logic                       ob_space;
    logic                       busy;
    logic [7:0]                 b;
    logic [31:0]                shifted;
    logic [31:0]                acc_new;
    logic                       sign_new;

    assign busy     = (rem_reg != '0);
    assign ob_pop   = pop && (ob_cnt_reg != 2'd0);
    assign ob_space = (ob_cnt_reg != 2'd2) || ob_pop;
    assign empty    = (ob_cnt_reg == 2'd0);
    assign res_head = ob_mem_reg[ob_rd_reg];
    assign b        = head.data[7:0];

    always_comb
    begin
        case (dcnt_reg)
            3'd1:    shifted = {19'd0, b[6:0], 6'd0};
            3'd2:    shifted = {12'd0, b[6:0], 13'd0};
            3'd3:    shifted = {5'd0, b[6:0], 20'd0};
            default: shifted = {b[4:0], 27'd0};
        endcase
        if (dcnt_reg == '0)
        begin
            acc_new  = {26'd0, b[5:0]};
            sign_new = b[6];
        end
        else
        begin
            acc_new  = acc_reg | shifted;
            sign_new = sign_reg;
        end
    end

    always_comb
    begin
        emit      = 1'b0;
        cmd_pop   = 1'b0;
        res       = '0;
        rem_next  = rem_reg;
        cur_next  = cur_reg;
        acc_next  = acc_reg;
        dcnt_next = dcnt_reg;
        sign_next = sign_reg;
        if (busy)
        begin
            if (ob_space)
            begin
                emit         = 1'b1;
                res.byte_out = {rem_reg > 3'd1, cur_reg[6:0]};
                res.last     = (rem_reg == 3'd1);
                cur_next     = cur_reg >> 7;
                rem_next     = rem_reg - 3'd1;
            end
        end
        else if (head_valid && ob_space)
        begin
            emit    = 1'b1;
            cmd_pop = 1'b1;
            if (head.dec)
            begin
                res.last = 1'b1;
                if (!b[7] || dcnt_reg == svc_pkg::MAX_DEC_CNT)
                begin
                    res.value_valid = 1'b1;
                    res.value_out   = sign_new ? ~acc_new : acc_new;
                    acc_next        = '0;
                    dcnt_next       = '0;
                    sign_next       = 1'b0;
                end
                else
                begin
                    acc_next  = acc_new;
                    dcnt_next = dcnt_reg + 3'd1;
                    sign_next = sign_new;
                end
            end
            else
            begin
                res.byte_out = {head.nbytes > 3'd1, head.sign, head.data[5:0]};
                res.last     = (head.nbytes == 3'd1);
                cur_next     = head.data[30:6];
                rem_next     = head.nbytes - 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg    <= '0;
            acc_reg    <= '0;
            dcnt_reg   <= '0;
            sign_reg   <= 1'b0;
            ob_wr_reg  <= 1'b0;
            ob_rd_reg  <= 1'b0;
            ob_cnt_reg <= 2'd0;
        end
        else
        begin
            rem_reg    <= rem_next;
            acc_reg    <= acc_next;
            dcnt_reg   <= dcnt_next;
            sign_reg   <= sign_next;
            ob_wr_reg  <= ob_wr_reg ^ emit;
            ob_rd_reg  <= ob_rd_reg ^ ob_pop;
            ob_cnt_reg <= ob_cnt_reg + {1'b0, emit} - {1'b0, ob_pop};
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        if (emit)
        begin
            ob_mem_reg[ob_wr_reg] <= res;
        end
    end

    `SVC_ASSERT_IMP(a_ob_bound, 1'b1, ob_cnt_reg != 2'd3, "output buffer overflow")
    `SVC_ASSERT_IMP(a_dcnt_bound, 1'b1, dcnt_reg <= svc_pkg::MAX_DEC_CNT, "decode count runaway")
    `SVC_ASSERT_IMP(a_no_pop_busy, busy, !cmd_pop, "request taken during encode burst")
    `SVC_ASSERT_NXT(a_last_idle, emit && res.last, rem_reg == '0, "encode burst not closed")

endmodule

### hw/rtl/signed_varint_codec.sv
// Top level of the signed varint codec: front end, request queue, back end.
// Depends on svc_pkg, svc_front, svc_cmd_q and svc_back.
`timescale 1ns / 1ps

// Usage
//   Input queue: drive value (encode) or byte_in (decode) and raise push;
//   the request is taken on a clock edge with push high and full low.
//   Result queue: while empty is low the oldest result sits on byte_out,
//   value_out, value_valid and last; pop high takes it.
//   cfg_data sets mode (0 encode, 1 decode); write only while idle.
//   cfg_ready is always high.
// Timing
//   First result of a request is visible once it has passed the request
//   queue and been written into the registered result buffer. Decode: one
//   byte per cycle sustained while results are popped, one result per byte.
//   Encode: 1 to 5 output bytes per integer from the back-end byte sequencer;
//   the two-entry request queue keeps input flowing while a burst is emitted.
// Reset
//   rst_n low clears mode to encode, empties both queues and clears the
//   decode accumulator, byte count and sign.
// Stalls
//   With pop low the two-entry result buffer fills, the back end halts,
//   then the request queue fills and full rises. Nothing is dropped.

module signed_varint_codec (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic signed [31:0]  value,
    input  logic [7:0]          byte_in,
    output logic                empty,
    input  logic                pop,
    output logic [7:0]          byte_out,
    output logic signed [31:0]  value_out,
    output logic                value_valid,
    output logic                last,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_data
);

    svc_pkg::cmd_t cmd;
    svc_pkg::cmd_t head;
    svc_pkg::res_t res_head;
    logic          cmd_push;
    logic          cmd_pop;
    logic          head_valid;

    assign cfg_ready = 1'b1;

    svc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .value     (value),
        .byte_in   (byte_in),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .q_full    (full),
        .cmd_push  (cmd_push),
        .cmd       (cmd)
    );

    svc_cmd_q u_cmd_q (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (cmd_push),
        .wr_data    (cmd),
        .rd_en      (cmd_pop),
        .head       (head),
        .head_valid (head_valid),
        .full       (full)
    );

    svc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (head_valid),
        .cmd_pop    (cmd_pop),
        .pop        (pop),
        .empty      (empty),
        .res_head   (res_head)
    );

    assign byte_out    = res_head.byte_out;
    assign value_out   = res_head.value_out;
    assign value_valid = res_head.value_valid;
    assign last        = res_head.last;

endmodule

### tb/tb_signed_varint_codec.sv
// Self-checking testbench for signed_varint_codec: encode and decode requests,
// mode writes, random stalls on both queues. Depends on svc_pkg and the codec RTL.
`timescale 1ns / 1ps

module tb_signed_varint_codec;

    localparam logic [7:0] EXT_FLAG  = 8'h80;
    localparam logic [7:0] SIGN_FLAG = 8'h40;
    localparam logic [7:0] HEAD_DATA = 8'h3F;
    localparam logic [7:0] TAIL_DATA = 8'h7F;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               push = 1'b0;
    logic               full;
    logic signed [31:0] value = '0;
    logic [7:0]         byte_in = '0;
    logic               empty;
    logic               pop = 1'b0;
    logic [7:0]         byte_out;
    logic signed [31:0] value_out;
    logic               value_valid;
    logic               last;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic               cfg_data = 1'b0;

    signed_varint_codec dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .value       (value),
        .byte_in     (byte_in),
        .empty       (empty),
        .pop         (pop),
        .byte_out    (byte_out),
        .value_out   (value_out),
        .value_valid (value_valid),
        .last        (last),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // codec state mirror
    logic        codec_mode = svc_pkg::MODE_ENCODE;
    logic [31:0] dec_acc = '0;
    logic [2:0]  dec_cnt = '0;
    logic        dec_sign = 1'b0;

    svc_pkg::res_t expected_results [$];
    int            send_idle = 0;
    int            recv_idle = 0;
    int            mismatches = 0;
    int            values_encoded = 0;
    int            bytes_decoded = 0;
    int            results_checked = 0;

    function automatic int varint_bytes(input logic [31:0] v, output logic [7:0] seq [0:4]);
        logic [31:0] u;
        int          n;
        u = v[31] ? ~v : v;
        seq[0] = (v[31] ? SIGN_FLAG : 8'h00) | (u[7:0] & HEAD_DATA);
        u = u >> 6;
        n = 1;
        while (u != 0)
        begin
            seq[n-1] = seq[n-1] | EXT_FLAG;
            seq[n] = u[7:0] & TAIL_DATA;
            u = u >> 7;
            n++;
        end
        return n;
    endfunction

    function automatic void predict(input logic [31:0] v, input logic [7:0] b);
        logic [7:0]    seq [0:4];
        int            n;
        int            pos;
        svc_pkg::res_t r;
        logic [31:0]   data;
        r = '0;
        if (codec_mode == svc_pkg::MODE_ENCODE)
        begin
            n = varint_bytes(v, seq);
            for (int k = 0; k < n; k++)
            begin
                r.byte_out = seq[k];
                r.last = (k == n - 1);
                expected_results.push_back(r);
            end
            values_encoded++;
        end
        else
        begin
            if (dec_cnt == 0)
            begin
                dec_sign = b[6];
                dec_acc = {24'd0, b & HEAD_DATA};
            end
            else
            begin
                pos = 6 + 7 * (int'(dec_cnt) - 1);
                data = {24'd0, b & TAIL_DATA};
                dec_acc = dec_acc | (data << pos);
            end
            r.last = 1'b1;
            if (!b[7] || dec_cnt >= svc_pkg::MAX_DEC_CNT)
            begin
                r.value_out = dec_sign ? ~dec_acc : dec_acc;
                r.value_valid = 1'b1;
                dec_acc = '0;
                dec_cnt = '0;
                dec_sign = 1'b0;
            end
            else
                dec_cnt = dec_cnt + 3'd1;
            expected_results.push_back(r);
            bytes_decoded++;
        end
    endfunction

    // result side: random pop and comparison
    always @(posedge clk)
    begin
        svc_pkg::res_t exp_r;
        svc_pkg::res_t act_r;
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && !empty)
            begin
                act_r.byte_out = byte_out;
                act_r.value_out = value_out;
                act_r.value_valid = value_valid;
                act_r.last = last;
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result byte=%02h value=%08h valid=%b last=%b",
                             $time, byte_out, value_out, value_valid, last);
                    mismatches++;
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    results_checked++;
                    if (act_r !== exp_r)
                    begin
                        $display("%0t: mismatch exp byte=%02h value=%08h valid=%b last=%b",
                                 $time, exp_r.byte_out, exp_r.value_out, exp_r.value_valid,
                                 exp_r.last);
                        $display("%0t:          got byte=%02h value=%08h valid=%b last=%b",
                                 $time, byte_out, value_out, value_valid, last);
                        mismatches++;
                    end
                end
            end
            pop <= ($urandom_range(99) >= recv_idle);
        end
    end

    task automatic send_req(input logic [31:0] v, input logic [7:0] b);
        while ($urandom_range(99) < send_idle)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        value <= v;
        byte_in <= b;
        @(posedge clk);
        while (full)
            @(posedge clk);
        predict(v, b);
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_mode(input logic m);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data <= m;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        codec_mode = m;
    endtask

    function automatic logic [31:0] rand_value();
        logic [31:0] r;
        r = $urandom >> $urandom_range(31);
        if ($urandom_range(1))
            r = ~r;
        return r;
    endfunction

    task automatic test_encode_extremes();
        logic [31:0] vals [10] = '{32'd0, 32'd63, 32'd64, 32'hFFFF_FFFF, 32'hFFFF_FFC0,
                                   32'hFFFF_FFBF, 32'd8191, 32'd8192, 32'h7FFF_FFFF,
                                   32'h8000_0000};
        write_mode(svc_pkg::MODE_ENCODE);
        foreach (vals[i])
            send_req(vals[i], 8'($urandom));
    endtask

    // single bytes, sign, five bytes with extend still set on the last, zero tail
    task automatic test_decode_extremes();
        logic [7:0] seq [10] = '{8'h00, 8'h7F, 8'h40, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                                 8'h81, 8'h00};
        write_mode(svc_pkg::MODE_DECODE);
        foreach (seq[i])
            send_req($urandom, seq[i]);
    endtask

    task automatic test_mode_switch_mid_value();
        write_mode(svc_pkg::MODE_DECODE);
        send_req($urandom, 8'h85);
        write_mode(svc_pkg::MODE_ENCODE);
        send_req(32'h1234_5678, 8'h00);
        write_mode(svc_pkg::MODE_DECODE);
        send_req($urandom, 8'h01);
    endtask

    task automatic test_random_encode(input int count);
        write_mode(svc_pkg::MODE_ENCODE);
        repeat (count)
        begin
            if ($urandom_range(15) == 0)
                wait_drained();
            send_req(rand_value(), 8'($urandom));
        end
    endtask

    task automatic test_random_decode(input int count);
        logic [7:0] seq [0:4];
        int         n;
        int         sent;
        write_mode(svc_pkg::MODE_DECODE);
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(15) == 0)
                wait_drained();
            case ($urandom_range(9))
                7:
                begin
                    n = varint_bytes(rand_value(), seq);
                    n = $urandom_range(n);
                end
                8:
                begin
                    seq[0] = 8'($urandom);
                    n = 1;
                end
                9:
                begin
                    foreach (seq[i])
                        seq[i] = 8'($urandom) | EXT_FLAG;
                    n = 5;
                end
                default:
                    n = varint_bytes(rand_value(), seq);
            endcase
            for (int k = 0; k < n; k++)
                send_req($urandom, seq[k]);
            sent += n;
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle = 33;
        recv_idle = 67;
        test_encode_extremes();
        test_decode_extremes();
        test_mode_switch_mid_value();
        test_random_encode(30);
        test_random_decode(35);
        send_idle = 67;
        recv_idle = 33;
        test_random_decode(35);
        test_random_encode(30);
        send_idle = 0;
        recv_idle = 0;
        test_random_encode(30);
        test_random_decode(35);

        wait_drained();
        repeat (10) @(posedge clk);

        $display("Encoded %0d values and decoded %0d bytes; %0d results checked.",
                 values_encoded, bytes_decoded, results_checked);
        $display("Covered both modes, mode writes mid-value and stalls on both queues.");
        if (mismatches == 0 && expected_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Timeout with %0d results outstanding", expected_results.size());
        $display("Regression FAIL");
        $finish;
    end

endmodule
